// ----- rtl/mui_pkg.sv -----
package mui_pkg;

    // Fixed field widths of the block's channels.
    localparam int IDX_W      = 32;
    localparam int CNT_W      = IDX_W + 1;
    localparam int POS_W      = 7;
    localparam int SYM_W      = 5;
    localparam int MUT_W      = 4;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_LEN = 64;
    localparam int DEF_MAX_MUT = 8;

    // Register reset values.
    localparam logic [POS_W-1:0] RST_SEQ_LENGTH    = POS_W'(50);
    localparam logic [SYM_W-1:0] RST_SYMBOL_COUNT  = SYM_W'(2);
    localparam logic [MUT_W-1:0] RST_MAX_MUTATIONS = MUT_W'(4);

    // Saturation points of the counts.
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(1) << IDX_W;
    localparam logic [IDX_W-1:0] IDX_SAT = '1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MUTATIONS = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_MUTATION    = 2'd0,
        ST_NO_MUTATION = 2'd1,
        ST_INVALID     = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_RANGE_MUL,
        S_RANGE_ADD,
        S_SPLIT,
        S_SPLIT_WAIT,
        S_DIG,
        S_DIG_WAIT,
        S_POS_TEST,
        S_POS_CMP,
        S_POS_EMIT,
        S_EMIT_INV,
        S_EMIT_NONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    init_step;
        logic    load;
        logic    rd_len;
        logic    range_mul;
        logic    range_add;
        logic    split_bypass;
        logic    div_start;
        logic    div_sel_digit;
        logic    split_take;
        logic    dig_take;
        logic    pos_setup;
        logic    pos_read;
        logic    pos_step;
        logic    emit;
        status_t emit_code;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic init_last;
        logic idx_zero;
        logic idx_one;
        logic mm_zero;
        logic found;
        logic last_i;
        logic qk_sat;
        logic div_done;
        logic dig_last;
        logic p_lt_lact;
        logic comb_lt_cnt;
        logic mut_last;
        logic out_full;
    } ctrl_stat_t;

endpackage

// ----- rtl/mui_if.sv -----
// Request channel: one sequence index per request.
interface mui_req_if
    import mui_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] seq_index;

    modport source (output valid, output seq_index, input ready);
    modport sink   (input valid, input seq_index, output ready);
endinterface

// Result channel: one mutation or one special outcome per result, the last of a request marked.
interface mui_res_if
    import mui_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [SYM_W-1:0]    symbol;
    logic                last;

    modport source (output valid, output status, output position, output symbol,
                    output last, input ready);
    modport sink   (input valid, input status, input position, input symbol,
                    input last, output ready);
endinterface

// Configuration write channel.
interface mui_cfg_if
    import mui_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/mutation_index_unranking_core.sv -----
// Mutation index unranking core. Each request carries a 32-bit sequence index and yields
// one result per mutated position in ascending order (position 1-based, symbol 1..q, last
// marked), or a single no-mutation result for index 1, or a single invalid result for
// index 0 or an index beyond the configured range. After reset the core fills its
// binomial table, MAX_LEN+1 rows (65 at the default), with the request channel not
// ready; configuration writes are taken throughout. Per request the core walks the
// mutation counts, splits the rank on the shared restoring divider (bypassed when q^k
// saturates), derives the symbol digits for each mutation on the same divider, and
// tries candidate positions in the combination search, which reads one table row per
// try. A finished result waits in an output register while the next request is
// accepted.
module mutation_index_unranking_core
    import mui_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN,
    parameter int MAX_MUT = DEF_MAX_MUT
) (
    input logic      clk,
    input logic      rst_n,
    mui_req_if.sink   request,
    mui_res_if.source result,
    mui_cfg_if.sink   cfg
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    mui_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    mui_datapath #(
        .MAX_LEN (MAX_LEN),
        .MAX_MUT (MAX_MUT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_wr       (cfg.valid & cfg.ready),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .seq_index    (request.seq_index),
        .res_valid    (result.valid),
        .res_ready    (result.ready),
        .res_status   (result.status),
        .res_position (result.position),
        .res_symbol   (result.symbol),
        .res_last     (result.last)
    );

endmodule

// ----- rtl/mui_ram.sv -----
module mui_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/mui_div.sv -----
module mui_div
    import mui_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [IDX_W-1:0] dividend,
    input  logic [IDX_W-1:0] divisor,
    output logic [IDX_W-1:0] quotient,
    output logic [IDX_W-1:0] remainder,
    output logic             done
);

    localparam int CW = $clog2(IDX_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [IDX_W:0]   rem_reg, rem_next;
    logic [IDX_W-1:0] quo_reg, quo_next;
    logic [IDX_W-1:0] div_reg, div_next;
    logic [IDX_W:0]   trial;

    // Restoring division, one quotient bit per cycle.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        trial     = {rem_reg[IDX_W-1:0], quo_reg[IDX_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = trial - {1'b0, div_reg};
                quo_next = {quo_reg[IDX_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[IDX_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(IDX_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg[IDX_W-1:0];
    assign done      = done_reg;

    // The finish pulse follows a busy cycle and never overlaps one.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("divider finished without running");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_busy_len: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not start");

endmodule

// ----- rtl/mui_datapath.sv -----
module mui_datapath
    import mui_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN,
    parameter int MAX_MUT = DEF_MAX_MUT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output ctrl_stat_t            stat,
    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [IDX_W-1:0]      seq_index,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [STATUS_W-1:0]   res_status,
    output logic [POS_W-1:0]      res_position,
    output logic [SYM_W-1:0]      res_symbol,
    output logic                  res_last
);

    localparam int NW   = $clog2(MAX_LEN + 1);
    localparam int MW   = $clog2(MAX_MUT + 1);
    localparam int DJW  = (MAX_MUT > 1) ? $clog2(MAX_MUT) : 1;
    localparam int COLS = MAX_MUT + 1;
    localparam int TW   = COLS * CNT_W;

    // Configuration registers.
    logic [POS_W-1:0] seq_length_reg;
    logic [SYM_W-1:0] symbol_count_reg;
    logic [MUT_W-1:0] max_mutations_reg;

    // Binomial table build.
    logic [CNT_W-1:0] row_reg [COLS];
    logic [CNT_W-1:0] row_next [COLS];
    logic [NW-1:0]    init_cnt_reg;
    logic [TW-1:0]    row_packed;

    // Table read port.
    logic [NW-1:0]    rd_addr;
    logic [TW-1:0]    rd_data;
    logic [CNT_W-1:0] rd_col [COLS];

    // Working registers.
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] range_reg;
    logic [MW-1:0]    i_reg;
    logic [CNT_W-1:0] pw_reg;
    logic [CNT_W-1:0] term_reg;
    logic [IDX_W-1:0] comb_reg;
    logic [IDX_W-1:0] x_reg;
    logic [DJW-1:0]   j_reg;
    logic [SYM_W-1:0] dig_reg [MAX_MUT];
    logic [NW-1:0]    lact_reg;
    logic [MW-1:0]    rem_reg;
    logic [NW-1:0]    base_reg;
    logic [NW-1:0]    p_reg;

    // Output register.
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [POS_W-1:0]    out_position_reg;
    logic [SYM_W-1:0]    out_symbol_reg;
    logic                out_last_reg;

    logic [NW-1:0]        len_w;
    logic [MW-1:0]        mm_w;
    logic [CNT_W-1:0]     binom_cur;
    logic [2*IDX_W-1:0]   prod;
    logic [CNT_W-1:0]     term_w;
    logic [IDX_W+1:0]     sum_w;
    logic [IDX_W-1:0]     range_new;
    logic [IDX_W+SYM_W-1:0] pwq;
    logic [CNT_W-1:0]     pw_step;
    logic [IDX_W-1:0]     r_val;
    logic [CNT_W-1:0]     cnt_w;
    logic [MW-1:0]        col_rem;
    logic [NW:0]          pos_sum;
    logic [IDX_W-1:0]     div_dividend;
    logic [IDX_W-1:0]     div_divisor;
    logic [IDX_W-1:0]     div_quo;
    logic [IDX_W-1:0]     div_rem;
    logic                 div_done;

    // Clamped configuration.
    assign len_w = (32'(seq_length_reg) > 32'(MAX_LEN)) ? NW'(MAX_LEN) : NW'(seq_length_reg);
    assign mm_w  = (32'(max_mutations_reg) > 32'(MAX_MUT)) ? MW'(MAX_MUT)
                                                           : MW'(max_mutations_reg);

    // Next Pascal row: each entry saturates at the count cap.
    always_comb
    begin
        row_next[0] = CNT_W'(1);
        for (int c = 1; c < COLS; c++)
        begin
            if ({1'b0, row_reg[c]} + {1'b0, row_reg[c-1]} >= {1'b0, CNT_CAP})
            begin
                row_next[c] = CNT_CAP;
            end
            else
            begin
                row_next[c] = row_reg[c] + row_reg[c-1];
            end
        end
        for (int c = 0; c < COLS; c++)
        begin
            row_packed[c*CNT_W +: CNT_W] = row_reg[c];
            rd_col[c] = rd_data[c*CNT_W +: CNT_W];
        end
    end

    assign rd_addr = cmd.rd_len ? len_w : (lact_reg - p_reg);

    mui_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_LEN + 1)
    ) u_table (
        .clk     (clk),
        .wr_en   (cmd.init_step),
        .wr_addr (init_cnt_reg),
        .wr_data (row_packed),
        .rd_en   (cmd.rd_len | cmd.pos_read),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Count term C(L,i) * q^i, saturated at the cap.
    always_comb
    begin
        binom_cur = rd_col[i_reg];
        prod      = {{IDX_W{1'b0}}, binom_cur[IDX_W-1:0]} *
                    {{IDX_W{1'b0}}, pw_reg[IDX_W-1:0]};
        if (binom_cur == '0 || pw_reg == '0)
        begin
            term_w = '0;
        end
        else if (binom_cur[IDX_W] || pw_reg[IDX_W] || prod[2*IDX_W-1:IDX_W] != '0)
        begin
            term_w = CNT_CAP;
        end
        else
        begin
            term_w = {1'b0, prod[IDX_W-1:0]};
        end
    end

    // Cumulative range and the next power of q.
    always_comb
    begin
        sum_w     = {2'b00, range_reg} + {1'b0, term_reg};
        range_new = (sum_w > {2'b00, IDX_SAT}) ? IDX_SAT : sum_w[IDX_W-1:0];
        pwq       = {{SYM_W{1'b0}}, pw_reg[IDX_W-1:0]} *
                    {{IDX_W{1'b0}}, symbol_count_reg};
        if (pw_reg[IDX_W] || pwq[IDX_W+SYM_W-1:IDX_W] != '0)
        begin
            pw_step = CNT_CAP;
        end
        else
        begin
            pw_step = {1'b0, pwq[IDX_W-1:0]};
        end
    end

    assign r_val   = idx_reg - range_reg - IDX_W'(1);
    assign col_rem = rem_reg - MW'(1);
    assign cnt_w   = rd_col[col_rem];
    assign pos_sum = {1'b0, base_reg} + {1'b0, p_reg};

    // Shared divider: rank split first, then one symbol digit per pass.
    assign div_dividend = cmd.div_sel_digit ? x_reg : r_val;
    assign div_divisor  = cmd.div_sel_digit ? IDX_W'(symbol_count_reg) : pw_reg[IDX_W-1:0];

    mui_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    // Control state: configuration, table build and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_length_reg    <= RST_SEQ_LENGTH;
            symbol_count_reg  <= RST_SYMBOL_COUNT;
            max_mutations_reg <= RST_MAX_MUTATIONS;
            init_cnt_reg      <= '0;
            out_valid_reg     <= 1'b0;
            for (int c = 0; c < COLS; c++)
            begin
                row_reg[c] <= (c == 0) ? CNT_W'(1) : '0;
            end
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_index)
                    CFG_SEQ_LENGTH:    seq_length_reg    <= cfg_data[POS_W-1:0];
                    CFG_SYMBOL_COUNT:  symbol_count_reg  <= cfg_data[SYM_W-1:0];
                    CFG_MAX_MUTATIONS: max_mutations_reg <= cfg_data[MUT_W-1:0];
                    default:           ;
                endcase
            end
            if (cmd.init_step)
            begin
                init_cnt_reg <= init_cnt_reg + 1'b1;
                row_reg      <= row_next;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg   <= seq_index;
            range_reg <= IDX_W'(1);
            i_reg     <= MW'(1);
            pw_reg    <= CNT_W'(symbol_count_reg);
            j_reg     <= '0;
        end
        if (cmd.range_mul)
        begin
            term_reg <= term_w;
        end
        if (cmd.range_add && !(range_new >= idx_reg))
        begin
            range_reg <= range_new;
            i_reg     <= i_reg + 1'b1;
            pw_reg    <= pw_step;
        end
        if (cmd.split_bypass)
        begin
            comb_reg <= '0;
            x_reg    <= r_val;
        end
        if (cmd.split_take)
        begin
            comb_reg <= div_quo;
            x_reg    <= div_rem;
        end
        if (cmd.dig_take)
        begin
            dig_reg[j_reg] <= div_rem[SYM_W-1:0];
            x_reg          <= div_quo;
            j_reg          <= j_reg + 1'b1;
        end
        if (cmd.pos_setup)
        begin
            lact_reg <= len_w;
            rem_reg  <= i_reg;
            base_reg <= '0;
            p_reg    <= NW'(1);
        end
        if (cmd.pos_step)
        begin
            comb_reg <= comb_reg - cnt_w[IDX_W-1:0];
            p_reg    <= p_reg + 1'b1;
        end
        if (cmd.emit)
        begin
            out_status_reg <= cmd.emit_code;
            if (cmd.emit_code == ST_MUTATION)
            begin
                out_position_reg <= POS_W'(pos_sum);
                out_symbol_reg   <= dig_reg[DJW'(col_rem)] + SYM_W'(1);
                out_last_reg     <= (rem_reg == MW'(1));
                base_reg         <= pos_sum[NW-1:0];
                lact_reg         <= (lact_reg >= p_reg) ? (lact_reg - p_reg) : '0;
                rem_reg          <= rem_reg - 1'b1;
                p_reg            <= NW'(1);
            end
            else
            begin
                out_position_reg <= '0;
                out_symbol_reg   <= '0;
                out_last_reg     <= 1'b1;
            end
        end
    end

    // Status towards the controller.
    always_comb
    begin
        stat.init_last   = (init_cnt_reg == NW'(MAX_LEN));
        stat.idx_zero    = (idx_reg == '0);
        stat.idx_one     = (idx_reg == IDX_W'(1));
        stat.mm_zero     = (mm_w == '0);
        stat.found       = (range_new >= idx_reg);
        stat.last_i      = (i_reg == mm_w);
        stat.qk_sat      = pw_reg[IDX_W];
        stat.div_done    = div_done;
        stat.dig_last    = (32'(j_reg) + 1 == 32'(i_reg));
        stat.p_lt_lact   = (p_reg < lact_reg);
        stat.comb_lt_cnt = ({1'b0, comb_reg} < cnt_w);
        stat.mut_last    = (rem_reg == MW'(1));
        stat.out_full    = out_valid_reg;
    end

    assign res_valid    = out_valid_reg;
    assign res_status   = out_status_reg;
    assign res_position = out_position_reg;
    assign res_symbol   = out_symbol_reg;
    assign res_last     = out_last_reg;

    // A result is never written over one still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !out_valid_reg)
        else $error("result overwritten");

    // The mutation count stays within the configured limit.
    a_i_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.range_mul |-> (i_reg != '0) && (i_reg <= mm_w))
        else $error("mutation count out of range");

    // A held result keeps its position and last flag until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_ready |=> $stable(out_position_reg) && $stable(out_last_reg))
        else $error("held result changed");

endmodule

// ----- rtl/mui_ctrl.sv -----
module mui_ctrl
    import mui_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    output ctrl_cmd_t  cmd,
    input  ctrl_stat_t stat
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencing of one request.
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.emit_code = ST_MUTATION;
        req_ready     = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd.init_step = 1'b1;
                if (stat.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.idx_zero)
                begin
                    state_next = S_EMIT_INV;
                end
                else if (stat.idx_one)
                begin
                    state_next = S_EMIT_NONE;
                end
                else if (stat.mm_zero)
                begin
                    state_next = S_EMIT_INV;
                end
                else
                begin
                    cmd.rd_len = 1'b1;
                    state_next = S_RANGE_MUL;
                end
            end
            S_RANGE_MUL:
            begin
                cmd.range_mul = 1'b1;
                state_next    = S_RANGE_ADD;
            end
            S_RANGE_ADD:
            begin
                cmd.range_add = 1'b1;
                if (stat.found)
                begin
                    state_next = S_SPLIT;
                end
                else if (stat.last_i)
                begin
                    state_next = S_EMIT_INV;
                end
                else
                begin
                    state_next = S_RANGE_MUL;
                end
            end
            S_SPLIT:
            begin
                if (stat.qk_sat)
                begin
                    cmd.split_bypass = 1'b1;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                end
                state_next = stat.qk_sat ? S_DIG : S_SPLIT_WAIT;
            end
            S_SPLIT_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.split_take = 1'b1;
                    state_next     = S_DIG;
                end
            end
            S_DIG:
            begin
                cmd.div_start     = 1'b1;
                cmd.div_sel_digit = 1'b1;
                state_next        = S_DIG_WAIT;
            end
            S_DIG_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.dig_take = 1'b1;
                    if (stat.dig_last)
                    begin
                        cmd.pos_setup = 1'b1;
                        state_next    = S_POS_TEST;
                    end
                    else
                    begin
                        state_next = S_DIG;
                    end
                end
            end
            S_POS_TEST:
            begin
                if (stat.p_lt_lact)
                begin
                    cmd.pos_read = 1'b1;
                    state_next   = S_POS_CMP;
                end
                else
                begin
                    state_next = S_POS_EMIT;
                end
            end
            S_POS_CMP:
            begin
                if (stat.comb_lt_cnt)
                begin
                    state_next = S_POS_EMIT;
                end
                else
                begin
                    cmd.pos_step = 1'b1;
                    state_next   = S_POS_TEST;
                end
            end
            S_POS_EMIT:
            begin
                if (!stat.out_full)
                begin
                    cmd.emit   = 1'b1;
                    state_next = stat.mut_last ? S_IDLE : S_POS_TEST;
                end
            end
            S_EMIT_INV:
            begin
                if (!stat.out_full)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_code = ST_INVALID;
                    state_next    = S_IDLE;
                end
            end
            S_EMIT_NONE:
            begin
                if (!stat.out_full)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_code = ST_NO_MUTATION;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The divider only reports back while it is being waited on.
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> (state_reg == S_SPLIT_WAIT || state_reg == S_DIG_WAIT))
        else $error("divider result not expected");

    // A table compare always follows the read issued for it.
    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POS_CMP |-> $past(state_reg) == S_POS_TEST)
        else $error("compare without table read");

    // The table is complete before any request is taken.
    a_init_first: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> state_reg == S_IDLE && !cmd.init_step)
        else $error("request taken during table build");

endmodule
